### hw/rtl/signed_binary_to_decimal_ascii_defines.svh
// Assertion macros shared by the decimal text converter RTL.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTH
// Implication checked on clk, disabled while rst_n is low.
`define BSTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on clk, disabled while rst_n is low.
`define BSTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSTD_ASSERT_IMP(lbl, ante, cons, msg)
`define BSTD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/bstd_pkg.sv
// Types and constants of the signed binary to decimal text converter.
package bstd_pkg;

  localparam int VALUE_BITS = 64;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // decimal digits that hold any VALUE_BITS-bit unsigned value
  localparam int DIGITS    = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_CNT_W = $clog2(DIGITS + 1);

  localparam logic [OUT_DATA_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [OUT_DATA_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [OUT_DATA_W-1:0] CHAR_NINE  = 8'd57;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic shift_digit;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/signed_binary_to_decimal_ascii.sv
// Each value is converted by a bit-serial shift of its 64 magnitude bits through the digit
// chain, then an optional minus sign and a digit-by-digit unload of the 20 digit cells.
// A new value is accepted only in idle, so the block does not take one while converting.
// Leading zero cells unload without output beats; then one character per cycle while out_tready allows.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out_tvalid.
// Digit cells hold no reset; they are cleared at the start of each conversion.
`include "signed_binary_to_decimal_ascii_defines.svh"

module signed_binary_to_decimal_ascii (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bstd_pkg::IN_DATA_W-1:0] in_tdata,   // [63:0] value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bstd_pkg::OUT_DATA_W-1:0] out_tdata, // [7:0] char_code
  output logic                           out_tlast   // last_char
);
  import bstd_pkg::*;

  state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]  dig_cnt_r, dig_cnt_nxt;
  logic                  started_r, started_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                  out_tlast_r, out_tlast_nxt;

  cell_ctl_t             ctl;
  digit_t                top_digit;
  logic                  in_beat;
  logic                  out_free;
  logic [VALUE_BITS-1:0] raw;
  logic                  skip;
  logic                  last_dig;

  assign raw      = in_tdata[VALUE_BITS-1:0];
  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign last_dig = (dig_cnt_r == DIG_CNT_W'(1));
  assign skip     = !started_r && (top_digit == '0) && !last_dig;

  bstd_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .bit_in    (mag_r[VALUE_BITS-1]),
    .top_digit (top_digit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_r == BIT_CNT_W'(1)) state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!skip && out_free && last_dig) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready      = 1'b0;
    ctl            = '0;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    bit_cnt_nxt    = bit_cnt_r;
    dig_cnt_nxt    = dig_cnt_r;
    started_nxt    = started_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_beat) begin
          neg_nxt     = raw[VALUE_BITS-1];
          mag_nxt     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS);
          ctl.clear   = 1'b1;
        end
      end
      ST_CONV: begin
        ctl.shift_bit = 1'b1;
        mag_nxt       = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt   = bit_cnt_r - BIT_CNT_W'(1);
        dig_cnt_nxt   = DIG_CNT_W'(DIGITS);
        started_nxt   = 1'b0;
      end
      ST_SIGN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = CHAR_MINUS;
          out_tlast_nxt  = 1'b0;
        end
      end
      ST_EMIT: begin
        if (skip) begin
          ctl.shift_digit = 1'b1;
          dig_cnt_nxt     = dig_cnt_r - DIG_CNT_W'(1);
        end else if (out_free) begin
          ctl.shift_digit = 1'b1;
          dig_cnt_nxt     = dig_cnt_r - DIG_CNT_W'(1);
          started_nxt     = 1'b1;
          out_tvalid_nxt  = 1'b1;
          out_tdata_nxt   = CHAR_ZERO + {4'b0000, top_digit};
          out_tlast_nxt   = last_dig;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    dig_cnt_r   <= dig_cnt_nxt;
    started_r   <= started_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `BSTD_ASSERT_NXT(a_accept_conv, in_beat, state_r == ST_CONV, "accepted beat did not start conversion")
  `BSTD_ASSERT_IMP(a_char_range, out_tvalid_r && (out_tdata_r != CHAR_MINUS), (out_tdata_r >= CHAR_ZERO) && (out_tdata_r <= CHAR_NINE), "character is not a digit")
  `BSTD_ASSERT_IMP(a_last_digit, out_tvalid_r && out_tlast_r, out_tdata_r != CHAR_MINUS, "sign flagged as last character")
  `BSTD_ASSERT_IMP(a_emit_count, state_r == ST_EMIT, dig_cnt_r != '0, "digit unload ran past the chain")

endmodule

### hw/rtl/bstd_cell.sv
// One BCD digit cell: clear, add-3 correction and shift, or digit hand-over.
module bstd_cell (
  input  logic              clk,
  input  bstd_pkg::cell_ctl_t ctl,
  input  logic              bit_in,
  input  bstd_pkg::digit_t  digit_in,
  output logic              bit_out,
  output bstd_pkg::digit_t  digit
);
  import bstd_pkg::*;

  localparam digit_t ADJ_LIMIT = 4'd5;
  localparam digit_t ADJ_ADD   = 4'd3;

  digit_t digit_r, digit_nxt;
  digit_t adj;

  assign adj     = (digit_r >= ADJ_LIMIT) ? digit_r + ADJ_ADD : digit_r;
  assign bit_out = adj[3];
  assign digit   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift_bit) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctl.shift_digit) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

### hw/rtl/bstd_chain.sv
// Row of BCD digit cells; bits enter at the low cell, digits leave at the top.
`include "signed_binary_to_decimal_ascii_defines.svh"

module bstd_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  bstd_pkg::cell_ctl_t ctl,
  input  logic              bit_in,
  output bstd_pkg::digit_t  top_digit
);
  import bstd_pkg::*;

  logic   [DIGITS-1:0] carry;
  digit_t              digits [DIGITS];

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    logic   cin;
    digit_t din;
    if (i == 0) begin : g_low
      assign cin = bit_in;
      assign din = '0;
    end else begin : g_mid
      assign cin = carry[i-1];
      assign din = digits[i-1];
    end
    bstd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (cin),
      .digit_in (din),
      .bit_out  (carry[i]),
      .digit    (digits[i])
    );
  end

  assign top_digit = digits[DIGITS-1];

  // the chain holds enough digit cells that nothing ever carries out of the top cell
  `BSTD_ASSERT_IMP(a_no_overflow, ctl.shift_bit, !carry[DIGITS-1], "carry out of top digit")

endmodule
